### rtl/mws_pkg.sv
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types and constants for the minimizer window select block:
// controller states, command and status bundles, reset values.
// ----------------------------------------------------------------------------
package mws_pkg;

  // default depth of the key history
  localparam int MAX_WINDOW_DEF = 32;

  // key and position widths
  localparam int KEY_W = 32;
  localparam int POS_W = 32;

  // window size register
  localparam int WSIZE_W = 6;
  localparam logic [WSIZE_W-1:0] WSIZE_RST = 6'd8;

  // all-ones key never wins, all-ones position means no minimum
  localparam logic [KEY_W-1:0] KEY_NONE = '1;
  localparam logic [POS_W-1:0] POS_NONE = '1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CHECK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take a key beat, write history, start a window
    logic scan_step;  // read one history entry, step the age counter
    logic emit;       // load the output register with the window minimum
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_full;   // the beat being accepted closes a window
    logic age_zero;   // the newest entry is being read
    logic dup;        // minimum equals the last emitted position
    logic out_free;   // output register can take a new beat
  } dp_sts_t;

endpackage

### rtl/mws_ctrl.sv
// ----------------------------------------------------------------------------
// mws_ctrl
// Controller: sequences accept, history scan, final compare and the
// duplicate check that decides whether a result beat is sent.
// ----------------------------------------------------------------------------
module mws_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  mws_pkg::dp_sts_t sts,
  output mws_pkg::dp_cmd_t cmd
);

  mws_pkg::state_t state_r;
  mws_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      mws_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.win_full) begin
            state_nxt = mws_pkg::ST_SCAN;
          end
        end
      end
      mws_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.age_zero) begin
          state_nxt = mws_pkg::ST_DRAIN;
        end
      end
      mws_pkg::ST_DRAIN: begin
        // last read word is compared in this cycle
        state_nxt = mws_pkg::ST_CHECK;
      end
      mws_pkg::ST_CHECK: begin
        if (sts.dup) begin
          state_nxt = mws_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mws_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/mws_datapath.sv
// ----------------------------------------------------------------------------
// mws_datapath
// Datapath: key history ring memory, position counter, running minimum,
// last emitted position and the output register.
// ----------------------------------------------------------------------------
module mws_datapath #(
  parameter int MAX_WINDOW = mws_pkg::MAX_WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mws_pkg::WSIZE_W-1:0]  cfg_wr_data,
  input  logic [mws_pkg::KEY_W-1:0]    in_key,
  input  logic                         in_seq_start,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [mws_pkg::POS_W-1:0]    out_pos,
  input  mws_pkg::dp_cmd_t             cmd,
  output mws_pkg::dp_sts_t             sts
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam logic [AW:0]   DEPTH   = (AW+1)'(MAX_WINDOW);
  localparam logic [AW-1:0] LAST_IX = AW'(MAX_WINDOW - 1);
  localparam logic [WW-1:0] WMAX    = WW'(MAX_WINDOW);

  // key history ring, newest entry at head
  logic [mws_pkg::KEY_W-1:0] mem [MAX_WINDOW];

  logic [mws_pkg::WSIZE_W-1:0] wsize_r;
  logic [AW-1:0]               head_r, head_nxt;
  logic [mws_pkg::POS_W-1:0]   cnt_r, cnt_nxt;
  logic [mws_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]               age_r;
  logic [AW-1:0]               rd_age_r;
  logic [AW-1:0]               rd_addr;
  logic [mws_pkg::KEY_W-1:0]   rd_data_r;
  logic                        rd_vld_r;
  logic [mws_pkg::KEY_W-1:0]   min_key_r;
  logic [mws_pkg::POS_W-1:0]   min_pos_r;
  logic [mws_pkg::POS_W-1:0]   last_r;
  logic                        emitted_any_r;
  logic                        out_valid_r;
  logic [mws_pkg::POS_W-1:0]   out_pos_r;
  logic [WW-1:0]               w_eff;
  logic [WW-1:0]               w_m1;
  logic [AW:0]                 addr_wide;

  // effective window size: zero acts as one, clamp at history depth
  always_comb begin
    if (wsize_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(wsize_r) > 32'(MAX_WINDOW)) begin
      w_eff = WMAX;
    end else begin
      w_eff = WW'(wsize_r);
    end
    w_m1 = w_eff - WW'(1);
  end

  // position of the incoming key and the saturating count after it
  always_comb begin
    pos_nxt  = in_seq_start ? '0 : cnt_r;
    cnt_nxt  = (pos_nxt == mws_pkg::POS_NONE) ? pos_nxt : pos_nxt + 1'b1;
    head_nxt = (head_r == LAST_IX) ? '0 : head_r + 1'b1;
  end

  // ring address of the entry at the current scan age
  always_comb begin
    if ({1'b0, head_r} >= {1'b0, age_r}) begin
      addr_wide = {1'b0, head_r} - {1'b0, age_r};
    end else begin
      addr_wide = {1'b0, head_r} + DEPTH - {1'b0, age_r};
    end
    rd_addr = addr_wide[AW-1:0];
  end

  // status to controller
  always_comb begin
    sts.win_full = (cnt_nxt >= 32'(w_eff));
    sts.age_zero = (age_r == '0);
    sts.dup      = emitted_any_r && (min_pos_r == last_r);
    sts.out_free = !out_valid_r || out_tready;
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= mws_pkg::WSIZE_RST;
    end else if (cfg_wr_en) begin
      wsize_r <= cfg_wr_data;
    end
  end

  // history write port
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[head_nxt] <= in_key;
    end
  end

  // history read port, registered
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_data_r <= mem[rd_addr];
      rd_age_r  <= age_r;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      cnt_r         <= '0;
      emitted_any_r <= 1'b0;
      last_r        <= '0;
      rd_vld_r      <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step;
      if (cmd.accept) begin
        head_r <= head_nxt;
        cnt_r  <= cnt_nxt;
        if (in_seq_start) begin
          emitted_any_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        emitted_any_r <= 1'b1;
        last_r        <= min_pos_r;
      end
    end
  end

  // scan age counter, oldest entry first
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      age_r <= AW'(w_m1);
      pos_r <= pos_nxt;
    end else if (cmd.scan_step && (age_r != '0)) begin
      age_r <= age_r - 1'b1;
    end
  end

  // running minimum, strict compare keeps the earliest position on a tie
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      min_key_r <= mws_pkg::KEY_NONE;
      min_pos_r <= mws_pkg::POS_NONE;
    end else if (rd_vld_r && (rd_data_r < min_key_r)) begin
      min_key_r <= rd_data_r;
      min_pos_r <= pos_r - mws_pkg::POS_W'(rd_age_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pos_r <= min_pos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_pos    = out_pos_r;

endmodule

### rtl/minimizer_window_select.sv
// ----------------------------------------------------------------------------
// minimizer_window_select
// Sliding window minimizer selection over a stream of 32-bit k-mer keys.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one key per beat (tdata = key, tuser = sequence start flag).
//   out_* carries one minimizer position per beat (tdata = position).
//   cfg_wr_en / cfg_wr_data write the window size (zero acts as one, values
//   above MAX_WINDOW act as MAX_WINDOW); write only while the block is idle.
// Sequence: a key that does not close a window is only stored. A key that
//   closes a window (w = effective window size) starts a scan that reads w
//   history entries, oldest first, one entry a cycle through the single read
//   port, then a drain step for the last compare and a check step for the
//   duplicate check; in_tready stays low from the scan through the check.
// Stall: a result waits in the output register; new keys are taken while it
//   waits, and the next result holds in the check step until it is taken.
// Reset: position count, last emitted position and the emitted flag clear,
//   window size returns to 8; history contents are not cleared.
// ----------------------------------------------------------------------------
module minimizer_window_select #(
  parameter int MAX_WINDOW = mws_pkg::MAX_WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // config
  input  logic                         cfg_wr_en,
  input  logic [mws_pkg::WSIZE_W-1:0]  cfg_wr_data,   // window_size
  // key stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,      // [31:0] key
  input  logic                         in_tuser,      // [0] seq_start
  // position stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata      // [31:0] min_position
);

  mws_pkg::dp_cmd_t cmd;
  mws_pkg::dp_sts_t sts;

  // controller
  mws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  mws_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_key       (in_tdata),
    .in_seq_start (in_tuser),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_pos      (out_tdata),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
